// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion macros, empty under synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// checked only out of reset
`define DEA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge
`define DEA_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define DEA_ASSERT(label, clk, rst_n, prop, msg)
`define DEA_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// ===== design/dea_pkg.sv =====
// ----------------------------------------------------------------------------
// dea_pkg
// types and constants of the directory extent accumulator
// ----------------------------------------------------------------------------
package dea_pkg;

    localparam logic [7:0] USER_LIMIT   = 8'h20;
    localparam logic [7:0] USER_DELETED = 8'he5;
    localparam logic [7:0] USER_MASK    = 8'h0f;
    localparam logic [7:0] CHAR_MASK    = 8'h7f;
    localparam logic [7:0] ATTR_BIT     = 8'h80;

    localparam int unsigned NAME_W = 56;
    localparam int unsigned FTYPE_W = 21;

    // configuration register indexes
    localparam logic [1:0] CFG_WIDE = 2'd0;
    localparam logic [1:0] CFG_KPB  = 2'd1;
    localparam logic [1:0] CFG_USER = 2'd2;

    typedef struct packed {
        logic        start_scan;
        logic [7:0]  user_byte;
        logic [63:0] name_bytes;
        logic [23:0] type_bytes;
        logic [7:0]  record_count;
        logic [63:0] pointers_low;
        logic [63:0] pointers_high;
    } t_item;

    typedef struct packed {
        logic        entry_counted;
        logic [5:0]  file_slot;
        logic        new_file;
        logic [15:0] file_records;
        logic [15:0] file_kbytes;
        logic [7:0]  file_extents;
        logic        file_read_only;
        logic        file_system;
        logic        block_conflict;
        logic        conflict_seen;
        logic [15:0] total_extents;
        logic [6:0]  file_count;
    } t_result;

    typedef struct packed {
        logic [NAME_W-1:0]  name;
        logic [FTYPE_W-1:0] ftype;
    } t_key;

    // what moves from cell to cell
    typedef struct packed {
        logic valid;
        logic hit;
        t_key key;
    } t_chain;

    typedef struct packed {
        logic [15:0] records;
        logic [15:0] kbytes;
        logic [7:0]  extents;
        logic        system;
        logic        read_only;
    } t_sums;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_SEARCH,
        S_SUMRD,
        S_SUMWR,
        S_PTR_RD,
        S_PTR_WR
    } t_state;

    // 7-bit name and type of an entry
    function automatic t_key f_key(input logic [63:0] name_bytes,
                                   input logic [23:0] type_bytes);
        t_key k;
        for (int i = 0; i < 8; i++) begin
            k.name[i*7 +: 7] = name_bytes[i*8 +: 7];
        end
        for (int i = 0; i < 3; i++) begin
            k.ftype[i*7 +: 7] = type_bytes[i*8 +: 7];
        end
        return k;
    endfunction

endpackage

// ===== design/dea_ram.sv =====
// ----------------------------------------------------------------------------
// dea_ram
// generic single write, single read RAM with registered read data
// ----------------------------------------------------------------------------
module dea_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 512,
    parameter int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== design/dea_cell.sv =====
// ----------------------------------------------------------------------------
// dea_cell
// one file slot: holds a name and type, compares the passing key
// ----------------------------------------------------------------------------
module dea_cell #(
    parameter int unsigned SW  = 6,
    parameter int unsigned CW  = 7,
    parameter int unsigned IDX = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  dea_pkg::t_chain i_chain,
    input  logic [SW-1:0]   i_idx,
    input  logic [CW-1:0]   i_count,
    input  logic            i_wr_en,
    input  logic [SW-1:0]   i_wr_idx,
    input  dea_pkg::t_key   i_wr_key,
    output dea_pkg::t_chain o_chain,
    output logic [SW-1:0]   o_idx
);
    import dea_pkg::*;

    t_key          r_key;
    t_chain        r_chain;
    logic [SW-1:0] r_idx;
    logic          w_match;

    // a slot takes part only once it is in use
    assign w_match = i_chain.valid && !i_chain.hit && (CW'(IDX) < i_count)
                     && (r_key == i_chain.key);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain.valid <= 1'b0;
        end else begin
            r_chain.valid <= i_chain.valid;
        end
        r_chain.hit <= i_chain.hit || w_match;
        r_chain.key <= i_chain.key;
        r_idx       <= w_match ? SW'(IDX) : i_idx;
        if (i_wr_en && (i_wr_idx == SW'(IDX))) begin
            r_key <= i_wr_key;
        end
    end

    assign o_chain = r_chain;
    assign o_idx   = r_idx;

endmodule

// ===== design/directory_extent_accumulator.sv =====
// ----------------------------------------------------------------------------
// directory_extent_accumulator
// per-file totals and block allocation check over a directory scan
// ----------------------------------------------------------------------------
// One item is taken while busy is low; its single result appears with o_valid
// for one cycle, in the same cycle as busy drops, and the receiver cannot stall
// it. After reset, and for every item with start_scan set, a clearing pass
// writes the allocation bitmap one byte a cycle, before the item is worked. An
// accepted extent then travels the chain of FILE_SLOTS slot cells, one cell a
// cycle, and the bitmap walk skips each zero or out-of-range pointer in S_PTR_RD
// and, for each one that is marked, reads its byte in S_PTR_RD and then tests
// and sets it in S_PTR_WR, stopping early at a conflict. An item carries sixteen
// narrow or eight wide pointers. A rejected item, and a new name when the table
// is full, skips the slot sums and the bitmap walk.
module directory_extent_accumulator #(
    parameter int unsigned FILE_SLOTS   = 64,
    parameter int unsigned BITMAP_BYTES = 512
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  dea_pkg::t_item   i_item,
    output logic             o_valid,
    output dea_pkg::t_result o_result,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [4:0]       i_cfg_data
);
    import dea_pkg::*;

    `include "assert_macros.svh"

    localparam int unsigned SW = (FILE_SLOTS > 1) ? $clog2(FILE_SLOTS) : 1;
    localparam int unsigned CW = $clog2(FILE_SLOTS + 1);
    localparam int unsigned AW = $clog2(BITMAP_BYTES);
    localparam int unsigned SUMS_W = $bits(t_sums);

    t_state r_state, n_state;

    logic          r_wide;
    logic [4:0]    r_kpb;
    logic [3:0]    r_user;
    logic [CW-1:0] r_count;
    logic [15:0]   r_total;
    logic          r_conflict;
    logic          r_resume;
    logic [AW-1:0] r_ca;
    logic [4:0]    r_pi;
    logic [4:0]    r_blks;
    logic [SW-1:0] r_slot;
    logic          r_created;
    t_item         r_item;
    t_result       r_res;

    // chain between the slot cells
    t_chain        w_chain [0:FILE_SLOTS];
    logic [SW-1:0] w_idx   [0:FILE_SLOTS];
    logic          w_cell_we;
    t_key          w_key;

    logic          w_accept;
    logic          w_user_ok;
    logic          w_done;
    logic          w_room;
    logic [127:0]  w_pb;
    logic [15:0]   w_ptr;
    logic          w_ptr_use;
    logic [4:0]    w_nptr;
    logic [15:0]   w_nz;
    logic [4:0]    w_blks;
    logic          w_more;

    logic          w_bm_we;
    logic [AW-1:0] w_bm_waddr;
    logic [7:0]    w_bm_wdata;
    logic [AW-1:0] w_bm_raddr;
    logic [7:0]    w_bm_rdata;
    logic [7:0]    w_mask;

    logic          w_sum_we;
    t_sums         w_sum_new;
    logic [SUMS_W-1:0] w_sum_rdata;
    t_sums         w_sum_old;

    assign w_accept = start && !busy;
    assign w_key    = f_key(r_item.name_bytes, r_item.type_bytes);
    assign w_user_ok = (r_item.user_byte < USER_LIMIT)
                       && (r_item.user_byte != USER_DELETED)
                       && ((r_item.user_byte & USER_MASK) == {4'd0, r_user});
    assign w_done   = w_chain[FILE_SLOTS].valid;
    assign w_room   = (r_count < CW'(FILE_SLOTS));

    // the key enters the chain in the check cycle
    assign w_chain[0] = '{valid: (r_state == S_CHECK) && w_user_ok, hit: 1'b0, key: w_key};
    assign w_idx[0]   = '0;

    // pointer selection
    assign w_pb   = {r_item.pointers_high, r_item.pointers_low};
    assign w_nptr = r_wide ? 5'd8 : 5'd16;
    always_comb begin
        if (r_wide) begin
            w_ptr = w_pb[r_pi[2:0]*16 +: 16];
        end else begin
            w_ptr = {8'd0, w_pb[r_pi[3:0]*8 +: 8]};
        end
        for (int i = 0; i < 16; i++) begin
            if (r_wide) begin
                w_nz[i] = (i < 8) ? (w_pb[i*16 +: 16] != 16'd0) : 1'b0;
            end else begin
                w_nz[i] = (w_pb[i*8 +: 8] != 8'd0);
            end
        end
    end
    assign w_blks    = 5'($countones(w_nz));
    assign w_ptr_use = (w_ptr != 16'd0)
                       && ({1'b0, w_ptr[15:3]} < 14'(BITMAP_BYTES));
    assign w_mask    = 8'd1 << w_ptr[2:0];

    // walk goes on while the block just read was free
    assign w_more = (r_pi != w_nptr) && r_res.entry_counted
                    && ((w_bm_rdata & w_mask) == 8'd0);

    assign w_sum_old = w_sum_rdata;
    always_comb begin
        t_sums base;
        base = r_created ? '0 : w_sum_old;
        w_sum_new.records   = base.records + {8'd0, r_item.record_count};
        w_sum_new.kbytes    = base.kbytes + 16'({11'd0, r_blks} * {11'd0, r_kpb});
        w_sum_new.extents   = base.extents + 8'd1;
        w_sum_new.read_only = base.read_only | ((r_item.type_bytes[7:0] & ATTR_BIT) != 8'd0);
        w_sum_new.system    = base.system | ((r_item.type_bytes[15:8] & ATTR_BIT) != 8'd0);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_ca == AW'(BITMAP_BYTES - 1)) begin
                    n_state = r_resume ? S_CHECK : S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_state = i_item.start_scan ? S_CLEAR : S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = w_user_ok ? S_SEARCH : S_PTR_WR;
            end
            S_SEARCH: begin
                if (w_done) begin
                    n_state = (w_chain[FILE_SLOTS].hit || w_room) ? S_SUMRD : S_PTR_WR;
                end
            end
            S_SUMRD:  n_state = S_SUMWR;
            S_SUMWR:  n_state = S_PTR_RD;
            S_PTR_RD: begin
                if (r_pi == w_nptr) begin
                    n_state = S_PTR_WR;
                end else if (w_ptr_use) begin
                    n_state = S_PTR_WR;
                end
            end
            S_PTR_WR: n_state = w_more ? S_PTR_RD : S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // the result strobe is registered from the last S_PTR_WR step, which every item passes
    logic r_fin;

    // outputs and control
    always_comb begin
        busy        = (r_state != S_IDLE);
        w_bm_we     = 1'b0;
        w_bm_waddr  = r_ca;
        w_bm_wdata  = 8'd0;
        w_bm_raddr  = AW'(w_ptr[15:3]);
        w_sum_we    = 1'b0;
        w_cell_we   = 1'b0;
        unique case (r_state)
            S_CLEAR:  w_bm_we = 1'b1;
            S_SEARCH: w_cell_we = w_done && !w_chain[FILE_SLOTS].hit && w_room;
            S_SUMWR:  w_sum_we = 1'b1;
            S_PTR_WR: begin
                if (w_more) begin
                    w_bm_we    = 1'b1;
                    w_bm_waddr = AW'(w_ptr[15:3]);
                    w_bm_wdata = w_bm_rdata | w_mask;
                end
            end
            default: ;
        endcase
    end

    assign o_valid = r_fin;
    always_comb begin
        o_result               = r_res;
        o_result.conflict_seen = r_conflict;
        o_result.total_extents = r_total;
        o_result.file_count    = 7'(r_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_wide     <= 1'b0;
            r_kpb      <= 5'd1;
            r_user     <= 4'd0;
            r_count    <= '0;
            r_total    <= 16'd0;
            r_conflict <= 1'b0;
            r_resume   <= 1'b0;
            r_ca       <= '0;
            r_pi       <= 5'd0;
            r_fin      <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fin   <= (r_state == S_PTR_WR) && !w_more;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_WIDE: r_wide <= i_cfg_data[0];
                    CFG_KPB:  r_kpb  <= i_cfg_data;
                    CFG_USER: r_user <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
            unique case (r_state)
                S_CLEAR: r_ca <= r_ca + AW'(1);
                S_IDLE: begin
                    if (w_accept) begin
                        r_resume <= 1'b1;
                        r_ca     <= '0;
                        r_pi     <= 5'd0;
                        if (i_item.start_scan) begin
                            r_count    <= '0;
                            r_total    <= 16'd0;
                            r_conflict <= 1'b0;
                        end
                    end
                end
                S_SEARCH: begin
                    if (w_done) begin
                        if (w_chain[FILE_SLOTS].hit) begin
                            r_slot <= w_idx[FILE_SLOTS];
                        end else if (w_room) begin
                            r_slot  <= SW'(r_count);
                            r_count <= r_count + CW'(1);
                        end
                    end
                end
                S_SUMWR: r_total <= r_total + 16'd1;
                S_PTR_RD: begin
                    if (r_pi != w_nptr && !w_ptr_use) begin
                        r_pi <= r_pi + 5'd1;
                    end
                end
                S_PTR_WR: begin
                    if (r_pi != w_nptr && r_res.entry_counted) begin
                        if ((w_bm_rdata & w_mask) != 8'd0) begin
                            r_conflict <= 1'b1;
                        end else begin
                            r_pi <= r_pi + 5'd1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // item payload and result fields
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && w_accept) begin
            r_item <= i_item;
            r_res  <= '0;
        end
        if (r_state == S_CHECK) begin
            r_blks <= w_blks;
        end
        if (r_state == S_SEARCH && w_done) begin
            r_created <= !w_chain[FILE_SLOTS].hit;
        end
        if (r_state == S_SUMWR) begin
            r_res.entry_counted  <= 1'b1;
            r_res.file_slot      <= 6'(r_slot);
            r_res.new_file       <= r_created;
            r_res.file_records   <= w_sum_new.records;
            r_res.file_kbytes    <= w_sum_new.kbytes;
            r_res.file_extents   <= w_sum_new.extents;
            r_res.file_read_only <= w_sum_new.read_only;
            r_res.file_system    <= w_sum_new.system;
        end
        if (r_state == S_PTR_WR && r_pi != w_nptr && r_res.entry_counted
            && ((w_bm_rdata & w_mask) != 8'd0)) begin
            r_res.block_conflict <= 1'b1;
        end
    end

    for (genvar g = 0; g < FILE_SLOTS; g++) begin : g_cell
        dea_cell #(
            .SW  (SW),
            .CW  (CW),
            .IDX (g)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_chain  (w_chain[g]),
            .i_idx    (w_idx[g]),
            .i_count  (r_count),
            .i_wr_en  (w_cell_we),
            .i_wr_idx (SW'(r_count)),
            .i_wr_key (w_key),
            .o_chain  (w_chain[g+1]),
            .o_idx    (w_idx[g+1])
        );
    end

    dea_ram #(
        .WIDTH (8),
        .DEPTH (BITMAP_BYTES)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (w_bm_we),
        .i_waddr (w_bm_waddr),
        .i_wdata (w_bm_wdata),
        .i_raddr (w_bm_raddr),
        .o_rdata (w_bm_rdata)
    );

    dea_ram #(
        .WIDTH (SUMS_W),
        .DEPTH (FILE_SLOTS)
    ) u_sums (
        .i_clk   (i_clk),
        .i_we    (w_sum_we),
        .i_waddr (r_slot),
        .i_wdata (w_sum_new),
        .i_raddr (r_slot),
        .o_rdata (w_sum_rdata)
    );

    `DEA_ASSERT(a_strobe_single, i_clk, i_rst_n, o_valid |=> !o_valid, "result strobe longer than one cycle")
    `DEA_ASSERT(a_accept_busy, i_clk, i_rst_n, w_accept |=> busy, "item accepted but block not busy")
    `DEA_ASSERT(a_count_range, i_clk, i_rst_n, r_count <= CW'(FILE_SLOTS), "slot count beyond table size")
    `DEA_ASSERT(a_reject_clean, i_clk, i_rst_n, (o_valid && !o_result.entry_counted) |-> (o_result.file_records == 16'd0 && !o_result.block_conflict && !o_result.new_file), "rejected item carries file data")
    `DEA_ASSERT(a_conflict_sticky, i_clk, i_rst_n, (o_valid && o_result.block_conflict) |-> o_result.conflict_seen, "conflict not recorded for the scan")

endmodule
